### hw/rtl/median_filter_3x3_assert.svh
// assertion macros for the median filter block
`ifndef MEDIAN_FILTER_3X3_ASSERT_SVH
`define MEDIAN_FILTER_3X3_ASSERT_SVH

// same-cycle implication, checked at every clock edge out of reset
`define MF3_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MF3_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/mf3_pkg.sv
`timescale 1ns / 1ps

package mf3_pkg;

   // entries in the queue between the window front and the median back
   localparam int QUEUE_DEPTH = 4;

   // reset geometry
   localparam logic [10:0] WIDTH_RESET  = 11'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;

   // register word indexes
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // one complete 3x3 window with its output position
   typedef struct packed {
      logic [8:0][7:0] win;
      logic [11:0]     row;
      logic [9:0]      col;
      logic            frame_end;
   } item_type;

   function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
      return (a < b) ? b : a;
   endfunction

   function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      return min2(min2(a, b), c);
   endfunction

   function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      return max2(max2(a, b), c);
   endfunction

   function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage

### hw/rtl/median_filter_3x3.sv
`timescale 1ns / 1ps
// 3x3 median filter on a raster-order stream of 8-bit grey pixels.
// req channel: one pixel per beat, req_frame_start marks row 0 column 0.
// rsp channel: one beat per interior pixel (not first/last row or column)
// with the median of its 3x3 neighborhood, its row and column, and
// rsp_frame_end on the last interior result of the frame.
// csr port: address 0 frame_width, address 4 frame_height (clamped to 3..MAX_*).
// the user writes them only while the block is idle; not enforced in the block.
// throughput: one pixel per clock while req_stall is low; the line stores
// take one read and one write per cycle; the window advances a column per pixel.
// a result for the window completed by an accepted pixel passes stage one,
// the queue and sort stages a, b and c before it is valid at the output.
// reset clears counters, window, queue and pipeline valids and loads the
// default geometry 640 x 480; line store contents are not cleared.
// rsp_stall holds the output beat; up to six finished windows wait behind it
// (two in the sort stages, four in the queue) before req_stall rises, so the
// front keeps taking pixels until then.
`include "median_filter_3x3_assert.svh"

module median_filter_3x3 #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_median_value,
   output logic [11:0] rsp_out_row,
   output logic [9:0]  rsp_out_col,
   output logic        rsp_frame_end,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [10:0] frame_width_ff;
   logic [12:0] frame_height_ff;
   logic        csr_write;

   logic              q_push, q_full, q_pop, q_valid;
   mf3_pkg::item_type q_push_item, q_head_item;

   // register port
   always_comb begin
      pready    = 1'b1;
      csr_write = psel && penable && pwrite && pready;
      unique case (paddr[2])
         mf3_pkg::REG_WIDTH:  prdata = 32'(frame_width_ff);
         mf3_pkg::REG_HEIGHT: prdata = 32'(frame_height_ff);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= mf3_pkg::WIDTH_RESET;
         frame_height_ff <= mf3_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         if (paddr[2] == mf3_pkg::REG_WIDTH) begin
            frame_width_ff <= pwdata[10:0];
         end else begin
            frame_height_ff <= pwdata[12:0];
         end
      end
   end

   mf3_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .frame_width     (frame_width_ff),
      .frame_height    (frame_height_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (q_push_item)
   );

   mf3_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (q_head_item)
   );

   mf3_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_head_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median_value (rsp_median_value),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_frame_end    (rsp_frame_end)
   );

   // the front never pushes into a full queue
   `MF3_ASSERT_NOW(a_no_push_full, q_push, !q_full, "window pushed into full queue")

   // the back only pops an entry that is there
   `MF3_ASSERT_NOW(a_pop_valid, q_pop, q_valid, "pop from empty queue")

   // a width write lands in the register
   `MF3_ASSERT_NEXT(a_width_write, csr_write && (paddr[2] == mf3_pkg::REG_WIDTH),
                    frame_width_ff == $past(pwdata[10:0]), "frame width write lost")

endmodule

### hw/rtl/mf3_front.sv
`timescale 1ns / 1ps

module mf3_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_pixel,
   input  logic               req_frame_start,
   input  logic [10:0]        frame_width,
   input  logic [12:0]        frame_height,
   input  logic               q_full,
   output logic               q_push,
   output mf3_pkg::item_type  q_item
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   // line stores: row two above and row one above, per column
   logic [7:0] mem_top [MAX_WIDTH];
   logic [7:0] mem_mid [MAX_WIDTH];

   logic [CW-1:0] col_count_ff, col_count_in;
   logic [RW-1:0] row_count_ff, row_count_in;

   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_px_ff;
   logic [CW-1:0] s1_col_ff;
   logic          s1_emit_ff;
   logic [11:0]   s1_row_out_ff;
   logic [9:0]    s1_col_out_ff;
   logic          s1_last_ff;

   logic [7:0]    rd_top_ff, rd_mid_ff;
   logic          fwd_ff, fwd_in;
   logic [7:0]    fwd_top_ff, fwd_mid_ff;

   logic [7:0]    win_ff [9];
   logic [7:0]    win_in [9];

   logic [31:0]   fw32, fh32, w_used, h_used;
   logic [CW-1:0] w_last, cur_col;
   logic [RW-1:0] h_last, cur_row;
   logic          row_end, frame_last, s1_go, accept;
   logic [7:0]    top_cur, mid_cur;

   // clamped geometry
   always_comb begin
      fw32 = 32'(frame_width);
      fh32 = 32'(frame_height);
      if (fw32 < 32'd3) begin
         w_used = 32'd3;
      end else if (fw32 > 32'(MAX_WIDTH)) begin
         w_used = 32'(MAX_WIDTH);
      end else begin
         w_used = fw32;
      end
      if (fh32 < 32'd3) begin
         h_used = 32'd3;
      end else if (fh32 > 32'(MAX_HEIGHT)) begin
         h_used = 32'(MAX_HEIGHT);
      end else begin
         h_used = fh32;
      end
      w_last = CW'(w_used - 32'd1);
      h_last = RW'(h_used - 32'd1);
   end

   // accept, position and counter update
   always_comb begin
      s1_go     = s1_valid_ff && (!s1_emit_ff || !q_full);
      req_stall = s1_valid_ff && !s1_go;
      accept    = req_valid && !req_stall;

      cur_col    = req_frame_start ? '0 : col_count_ff;
      cur_row    = req_frame_start ? '0 : row_count_ff;
      row_end    = (cur_col >= w_last);
      frame_last = row_end && (cur_row >= h_last);

      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         if (row_end) begin
            col_count_in = '0;
            row_count_in = frame_last ? '0 : cur_row + RW'(1);
         end else begin
            col_count_in = cur_col + CW'(1);
            row_count_in = cur_row;
         end
      end

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      // same column written back at this edge: take the new bytes
      fwd_in = s1_go && (s1_col_ff == cur_col);
   end

   // column history and window shift
   always_comb begin
      top_cur = fwd_ff ? fwd_top_ff : rd_top_ff;
      mid_cur = fwd_ff ? fwd_mid_ff : rd_mid_ff;

      for (int i = 0; i < 9; i++) begin
         win_in[i] = win_ff[i];
      end
      if (s1_go) begin
         for (int k = 0; k < 3; k++) begin
            win_in[k*3]   = win_ff[k*3+1];
            win_in[k*3+1] = win_ff[k*3+2];
         end
         win_in[2] = top_cur;
         win_in[5] = mid_cur;
         win_in[8] = s1_px_ff;
      end

      q_push = s1_go && s1_emit_ff;
      for (int i = 0; i < 9; i++) begin
         q_item.win[i] = win_in[i];
      end
      q_item.row       = s1_row_out_ff;
      q_item.col       = s1_col_out_ff;
      q_item.frame_end = s1_last_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         s1_valid_ff  <= s1_valid_in;
         if (accept) begin
            fwd_ff <= fwd_in;
         end
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff      <= req_pixel;
         s1_col_ff     <= cur_col;
         s1_emit_ff    <= (cur_row >= RW'(2)) && (cur_col >= CW'(2));
         s1_row_out_ff <= 12'(cur_row - RW'(1));
         s1_col_out_ff <= 10'(cur_col - CW'(1));
         s1_last_ff    <= frame_last;
         fwd_top_ff    <= mid_cur;
         fwd_mid_ff    <= s1_px_ff;
      end
   end

   // line store ports: one read and one write per cycle each
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_top_ff <= mem_top[cur_col];
         rd_mid_ff <= mem_mid[cur_col];
      end
      if (s1_go) begin
         mem_top[s1_col_ff] <= mid_cur;
         mem_mid[s1_col_ff] <= s1_px_ff;
      end
   end

endmodule

### hw/rtl/mf3_fifo.sv
`timescale 1ns / 1ps

module mf3_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mf3_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output mf3_pkg::item_type  head_item
);

   localparam int DEPTH = mf3_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);

   mf3_pkg::item_type entry_ff [DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   // pointer and fill update
   always_comb begin
      full       = (count_ff == (PW+1)'(DEPTH));
      head_valid = (count_ff != '0);
      head_item  = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hw/rtl/mf3_back.sv
`timescale 1ns / 1ps

module mf3_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  mf3_pkg::item_type  q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_median_value,
   output logic [11:0]        rsp_out_row,
   output logic [9:0]         rsp_out_col,
   output logic               rsp_frame_end
);

   // stage a: each window row sorted low to high
   logic             a_valid_ff;
   logic [2:0][7:0]  a_lo_ff, a_md_ff, a_hi_ff;
   logic [11:0]      a_row_ff;
   logic [9:0]       a_col_ff;
   logic             a_end_ff;

   // stage b: max of lows, median of middles, min of highs
   logic             b_valid_ff;
   logic [7:0]       b_lo_ff, b_md_ff, b_hi_ff;
   logic [11:0]      b_row_ff;
   logic [9:0]       b_col_ff;
   logic             b_end_ff;

   // stage c: output register
   logic             c_valid_ff;
   logic [7:0]       c_med_ff;
   logic [11:0]      c_row_ff;
   logic [9:0]       c_col_ff;
   logic             c_end_ff;

   logic out_free, b_go, b_free, a_go, a_free;

   // stall chain from the output back to the queue
   always_comb begin
      out_free = !c_valid_ff || !rsp_stall;
      b_go     = b_valid_ff && out_free;
      b_free   = !b_valid_ff || out_free;
      a_go     = a_valid_ff && b_free;
      a_free   = !a_valid_ff || b_free;
      q_pop    = q_valid && a_free;

      rsp_valid        = c_valid_ff;
      rsp_median_value = c_med_ff;
      rsp_out_row      = c_row_ff;
      rsp_out_col      = c_col_ff;
      rsp_frame_end    = c_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_free) begin
            a_valid_ff <= q_valid;
         end
         if (b_free) begin
            b_valid_ff <= a_go;
         end
         if (out_free) begin
            c_valid_ff <= b_go;
         end
      end
   end

   // row sort
   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int k = 0; k < 3; k++) begin
            a_lo_ff[k] <= mf3_pkg::min3(q_item.win[k*3], q_item.win[k*3+1],
                                        q_item.win[k*3+2]);
            a_md_ff[k] <= mf3_pkg::med3(q_item.win[k*3], q_item.win[k*3+1],
                                        q_item.win[k*3+2]);
            a_hi_ff[k] <= mf3_pkg::max3(q_item.win[k*3], q_item.win[k*3+1],
                                        q_item.win[k*3+2]);
         end
         a_row_ff <= q_item.row;
         a_col_ff <= q_item.col;
         a_end_ff <= q_item.frame_end;
      end
   end

   // column reduce
   always_ff @(posedge clock) begin
      if (a_go) begin
         b_lo_ff  <= mf3_pkg::max3(a_lo_ff[0], a_lo_ff[1], a_lo_ff[2]);
         b_md_ff  <= mf3_pkg::med3(a_md_ff[0], a_md_ff[1], a_md_ff[2]);
         b_hi_ff  <= mf3_pkg::min3(a_hi_ff[0], a_hi_ff[1], a_hi_ff[2]);
         b_row_ff <= a_row_ff;
         b_col_ff <= a_col_ff;
         b_end_ff <= a_end_ff;
      end
   end

   // final median of three
   always_ff @(posedge clock) begin
      if (b_go) begin
         c_med_ff <= mf3_pkg::med3(b_lo_ff, b_md_ff, b_hi_ff);
         c_row_ff <= b_row_ff;
         c_col_ff <= b_col_ff;
         c_end_ff <= b_end_ff;
      end
   end

endmodule
